// ----- src/olst_pkg.sv -----
// Package for the positional ordered list core.
// Holds field widths, command and status codes, and request/response types.
// No dependencies.
package olst_pkg;

   // Field widths fixed by the interface
   localparam int CMD_W  = 2;
   localparam int POS_W  = 7;
   localparam int WORD_W = 32;
   localparam int STAT_W = 2;

   // Default list capacity
   localparam int CAPACITY_DEF = 64;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic [POS_W-1:0]         position;
      logic signed [WORD_W-1:0] value;
   } olst_req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  found_position;
      logic [POS_W-1:0]  entry_count;
   } olst_rsp_type;

endpackage

// ----- src/olst_ram.sv -----
// Entry storage for the positional ordered list core.
// One write port, one read port with registered read data. Uses olst_pkg widths.
module olst_ram #(
   parameter int DEPTH = olst_pkg::CAPACITY_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                           clock,
   input  logic                           we,
   input  logic [AW-1:0]                  waddr,
   input  logic [olst_pkg::WORD_W-1:0]    wdata,
   input  logic [AW-1:0]                  raddr,
   output logic [olst_pkg::WORD_W-1:0]    rdata_ff
);

   logic [olst_pkg::WORD_W-1:0] mem [DEPTH];

   // Write on request, read every cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

// ----- src/positional_ordered_list_core.sv -----
// Positional ordered list core: sequencer, count and response register.
// Depends on olst_pkg and olst_ram.
//
// Usage:
//   The request channel (req_valid/req_ready/req_payload) takes one command:
//   insert a value at a 1-based position, delete the entry at a position, or
//   search for the first entry equal to a value. Every request yields one
//   response on rsp_valid/rsp_ready/rsp_payload with status, found position
//   (search only) and the entry count after the command. One shared
//   read/compare path walks the entry RAM one entry a cycle, so the RAM read
//   port sets the speed. Insert moves entries back from the tail, delete moves
//   them forward over the removed slot and search stops at the first match;
//   a bad position, a full list or an unused code skips the walk.
//   req_ready is high only while idle, so the next request is taken once the
//   response has been posted. A stalled response waits in the output register
//   and the sequencer holds its result until it is free. Reset empties the
//   list (count zero) and drops any response; no clearing pass is needed,
//   entries are only read below the count.
module positional_ordered_list_core #(
   parameter int CAPACITY = olst_pkg::CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  olst_pkg::olst_req_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output olst_pkg::olst_rsp_type rsp_payload
);

   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int PW    = olst_pkg::POS_W;
   localparam int CMPW  = ((CW > PW) ? CW : PW) + 1;
   localparam int WW    = olst_pkg::WORD_W;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_INS  = 5'b00010,
      S_DEL  = 5'b00100,
      S_SCAN = 5'b01000,
      S_FIN  = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic [PW-1:0]              pos_ff, pos_in;
   logic signed [WW-1:0]       val_ff, val_in;
   logic [CW-1:0]              k_ff, k_in;
   logic [AW-1:0]              dst_ff, dst_in;
   logic                       pend_ff, pend_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [olst_pkg::STAT_W-1:0] status_ff, status_in;
   logic [PW-1:0]              found_ff, found_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   olst_pkg::olst_rsp_type     rsp_ff, rsp_in;

   logic                       ram_we;
   logic [AW-1:0]              ram_waddr;
   logic [WW-1:0]              ram_wdata;
   logic [AW-1:0]              ram_raddr;
   logic [WW-1:0]              ram_rdata;

   logic [CMPW-1:0]            req_pos_x;
   logic [CMPW-1:0]            count_x;
   logic [CW-1:0]              pos_cw;

   olst_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .raddr    (ram_raddr),
      .rdata_ff (ram_rdata)
   );

   assign req_pos_x   = CMPW'(req_payload.position);
   assign count_x     = CMPW'(count_ff);
   assign pos_cw      = CW'(pos_ff);
   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Sequencer: decode, walk the RAM one entry a cycle, post the response
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      k_in         = k_ff;
      dst_in       = dst_ff;
      pend_in      = pend_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = dst_ff;
      ram_wdata    = ram_rdata;
      ram_raddr    = AW'(k_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pos_in    = req_payload.position;
               val_in    = req_payload.value;
               pend_in   = 1'b0;
               found_in  = '0;
               status_in = olst_pkg::ST_OK;
               unique case (req_payload.command)
                  olst_pkg::CMD_INSERT: begin
                     if (req_pos_x == '0 || req_pos_x > count_x + 1'b1) begin
                        status_in = olst_pkg::ST_RANGE;
                        state_in  = S_FIN;
                     end else if (count_x == CMPW'(CAPACITY)) begin
                        status_in = olst_pkg::ST_FULL;
                        state_in  = S_FIN;
                     end else begin
                        k_in     = count_ff;
                        state_in = S_INS;
                     end
                  end
                  olst_pkg::CMD_DELETE: begin
                     if (req_pos_x == '0 || req_pos_x > count_x) begin
                        status_in = olst_pkg::ST_RANGE;
                        state_in  = S_FIN;
                     end else begin
                        k_in     = CW'(req_payload.position);
                        state_in = S_DEL;
                     end
                  end
                  olst_pkg::CMD_SEARCH: begin
                     k_in     = '0;
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end

         // Move entries back from the tail, then drop the new value in
         S_INS: begin
            if (pend_ff) begin
               ram_we = 1'b1;
            end
            if (k_ff >= pos_cw) begin
               ram_raddr = AW'(k_ff - 1'b1);
               dst_in    = AW'(k_ff);
               k_in      = k_ff - 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  ram_we    = 1'b1;
                  ram_waddr = AW'(pos_cw - 1'b1);
                  ram_wdata = val_ff;
                  count_in  = count_ff + 1'b1;
                  state_in  = S_FIN;
               end
            end
         end

         // Move entries forward over the removed slot
         S_DEL: begin
            if (pend_ff) begin
               ram_we = 1'b1;
            end
            if (k_ff < count_ff) begin
               ram_raddr = AW'(k_ff);
               dst_in    = AW'(k_ff - 1'b1);
               k_in      = k_ff + 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = count_ff - 1'b1;
                  state_in = S_FIN;
               end
            end
         end

         // Compare one entry a cycle, stop at the first match
         S_SCAN: begin
            if (pend_ff && ram_rdata == val_ff) begin
               found_in = PW'(CW'(dst_ff) + 1'b1);
               pend_in  = 1'b0;
               state_in = S_FIN;
            end else if (k_ff < count_ff) begin
               ram_raddr = AW'(k_ff);
               dst_in    = AW'(k_ff);
               k_in      = k_ff + 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_FIN;
               end
            end
         end

         // Hand the result over once the output register is free
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = status_ff;
               rsp_in.found_position = found_ff;
               rsp_in.entry_count    = PW'(count_ff);
               state_in              = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and work registers
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      k_ff      <= k_in;
      dst_ff    <= dst_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      rsp_ff    <= rsp_in;
   end

endmodule

// ----- src/olst_check.sv -----
// Port-level checker for the positional ordered list core, with its bind.
// Depends on olst_pkg and positional_ordered_list_core.
module olst_check #(
   parameter int CAPACITY = olst_pkg::CAPACITY_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input olst_pkg::olst_rsp_type rsp_payload
);

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   // One request in work at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Status is a defined code
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == olst_pkg::ST_OK ||
                     rsp_payload.status == olst_pkg::ST_RANGE ||
                     rsp_payload.status == olst_pkg::ST_FULL))
      else $error("undefined status code");

   // A hit comes only with an ok status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.found_position != '0 |->
         rsp_payload.status == olst_pkg::ST_OK)
      else $error("found position with error status");

   // Count never exceeds capacity where the field can show it
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (CAPACITY < 128) |->
         32'(rsp_payload.entry_count) <= 32'(CAPACITY))
      else $error("entry count above capacity");

endmodule

bind positional_ordered_list_core olst_check #(.CAPACITY(CAPACITY)) u_olst_check (.*);

// ----- dv/tb_positional_ordered_list_core.sv -----
// Self-checking testbench for positional_ordered_list_core: directed and random requests
// checked against a shadow copy of the list kept in a small scoreboard class.
// Depends on olst_pkg and the core RTL only.
module tb_positional_ordered_list_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_CAP = olst_pkg::CAPACITY_DEF;
   localparam int PHASE_ITEMS = 435;
   localparam int SEGMENT_ITEMS = 100;
   localparam int TAIL_CYCLES = 2 * LIST_CAP + 20;
   localparam longint CYCLE_LIMIT = 1000000;
   localparam logic [olst_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_mode_type;

   // Shadow of the list plus the queue of responses still owed by the core
   class olst_scoreboard;
      logic signed [olst_pkg::WORD_W-1:0] shadow_entries [LIST_CAP];
      int unsigned shadow_count;
      olst_pkg::olst_rsp_type awaited_rsp_q[$];
      int unsigned error_count;

      function new();
         shadow_count = 0;
         error_count = 0;
      endfunction

      // Apply one accepted request to the shadow list and queue its response
      function void note_request(olst_pkg::olst_req_type r);
         olst_pkg::olst_rsp_type e;
         int unsigned pos;
         int unsigned found;
         logic [olst_pkg::STAT_W-1:0] stat;
         pos = r.position;
         found = 0;
         stat = olst_pkg::ST_OK;
         unique case (r.command)
            olst_pkg::CMD_INSERT: begin
               if (pos < 1 || pos > shadow_count + 1) begin
                  stat = olst_pkg::ST_RANGE;
               end else if (shadow_count >= LIST_CAP) begin
                  stat = olst_pkg::ST_FULL;
               end else begin
                  for (int k = shadow_count; k > int'(pos) - 1; k--)
                     shadow_entries[k] = shadow_entries[k-1];
                  shadow_entries[pos-1] = r.value;
                  shadow_count++;
               end
            end
            olst_pkg::CMD_DELETE: begin
               if (pos < 1 || pos > shadow_count) begin
                  stat = olst_pkg::ST_RANGE;
               end else begin
                  for (int k = pos - 1; k + 1 < int'(shadow_count); k++)
                     shadow_entries[k] = shadow_entries[k+1];
                  shadow_count--;
               end
            end
            olst_pkg::CMD_SEARCH: begin
               // keep the first match only
               for (int k = 0; k < int'(shadow_count); k++)
                  if (found == 0 && shadow_entries[k] == r.value)
                     found = k + 1;
            end
            default: begin
            end
         endcase
         e.status = stat;
         e.found_position = found[olst_pkg::POS_W-1:0];
         e.entry_count = shadow_count[olst_pkg::POS_W-1:0];
         awaited_rsp_q.push_back(e);
      endfunction

      // Compare one accepted response with the oldest one owed
      function void check_response(olst_pkg::olst_rsp_type r);
         olst_pkg::olst_rsp_type e;
         if (awaited_rsp_q.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual %p", $time, r);
            error_count++;
            return;
         end
         e = awaited_rsp_q.pop_front();
         if (r.status !== e.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, e.status, r.status);
            error_count++;
         end
         if (r.found_position !== e.found_position) begin
            $display("%0t: found_position mismatch: expected %0d, actual %0d",
                     $time, e.found_position, r.found_position);
            error_count++;
         end
         if (r.entry_count !== e.entry_count) begin
            $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                     $time, e.entry_count, r.entry_count);
            error_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   olst_pkg::olst_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   olst_pkg::olst_rsp_type rsp_payload;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   longint cycle_count = 0;
   olst_scoreboard sb = new();

   positional_ordered_list_core #(
      .CAPACITY(LIST_CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stall the response channel at the current rate
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_payload);
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic olst_pkg::olst_req_type make_req(
         logic [olst_pkg::CMD_W-1:0] cmd, int unsigned pos,
         logic signed [olst_pkg::WORD_W-1:0] val);
      olst_pkg::olst_req_type r;
      r.command = cmd;
      r.position = pos[olst_pkg::POS_W-1:0];
      r.value = val;
      return r;
   endfunction

   // Build one random request, biased by the mix mode and the current fill level
   function automatic olst_pkg::olst_req_type random_req(mix_mode_type mode);
      olst_pkg::olst_req_type r;
      int unsigned roll;
      int unsigned held;
      int unsigned ins_lim;
      int unsigned del_lim;
      int unsigned pick;
      logic signed [olst_pkg::WORD_W-1:0] val;
      held = sb.shadow_count;
      roll = $urandom_range(99);
      unique case (mode)
         MIX_FILL: begin
            ins_lim = 75;
            del_lim = 85;
         end
         MIX_DRAIN: begin
            ins_lim = 15;
            del_lim = 80;
         end
         default: begin
            ins_lim = 40;
            del_lim = 70;
         end
      endcase
      if (roll < 3)
         r.command = CMD_UNUSED;
      else if (roll < ins_lim)
         r.command = olst_pkg::CMD_INSERT;
      else if (roll < del_lim)
         r.command = olst_pkg::CMD_DELETE;
      else
         r.command = olst_pkg::CMD_SEARCH;

      // mostly legal positions, some anywhere in the field
      if ($urandom_range(99) < 15)
         pick = $urandom_range(127);
      else if (r.command == olst_pkg::CMD_INSERT)
         pick = $urandom_range(held + 1, 1);
      else if (r.command == olst_pkg::CMD_DELETE && held > 0)
         pick = $urandom_range(held, 1);
      else
         pick = $urandom_range(127);
      r.position = pick[olst_pkg::POS_W-1:0];

      // small values give duplicates, so first-match ordering gets exercised
      roll = $urandom_range(99);
      if (r.command == olst_pkg::CMD_SEARCH && held > 0 && roll < 50) begin
         val = sb.shadow_entries[$urandom_range(held - 1)];
      end else if (roll < 75) begin
         val = $urandom_range(15);
         val = val - 8;
      end else if (roll < 80) begin
         val = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      end else begin
         val = $urandom;
      end
      r.value = val;
      return r;
   endfunction

   // Offer one request; entered and left at a falling edge
   task automatic send_request(olst_pkg::olst_req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do
         @(posedge clock);
      while (!req_ready);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic run_random_phase(int unsigned idle_pct, int unsigned stall_pct);
      mix_mode_type mode;
      mode = MIX_FILL;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         // start each phase by filling, then pick a mix per segment
         if (i != 0 && i % SEGMENT_ITEMS == 0)
            mode = mix_mode_type'($urandom_range(2));
         send_request(random_req(mode));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty list, bad positions, extremes, duplicates, unused code
      send_request(make_req(olst_pkg::CMD_SEARCH, 0, 0));
      send_request(make_req(olst_pkg::CMD_DELETE, 1, 0));
      send_request(make_req(olst_pkg::CMD_INSERT, 0, 5));
      send_request(make_req(olst_pkg::CMD_INSERT, 2, 5));
      send_request(make_req(olst_pkg::CMD_INSERT, 1, 32'sh7FFF_FFFF));
      send_request(make_req(olst_pkg::CMD_INSERT, 2, 32'sh8000_0000));
      send_request(make_req(olst_pkg::CMD_INSERT, 1, -1));
      send_request(make_req(olst_pkg::CMD_INSERT, 2, 0));
      send_request(make_req(olst_pkg::CMD_INSERT, 127, 7));
      send_request(make_req(olst_pkg::CMD_SEARCH, 0, 32'sh8000_0000));
      send_request(make_req(olst_pkg::CMD_SEARCH, 0, 32'sh7FFF_FFFF));
      send_request(make_req(olst_pkg::CMD_SEARCH, 127, 12345));
      send_request(make_req(olst_pkg::CMD_INSERT, 5, -1));
      send_request(make_req(olst_pkg::CMD_SEARCH, 1, -1));
      send_request(make_req(CMD_UNUSED, 1, 0));
      send_request(make_req(CMD_UNUSED, 127, -1));
      send_request(make_req(olst_pkg::CMD_DELETE, 0, 0));
      send_request(make_req(olst_pkg::CMD_DELETE, 6, 0));
      send_request(make_req(olst_pkg::CMD_DELETE, 127, 0));
      send_request(make_req(olst_pkg::CMD_INSERT, 3, 32'sh5555_5555));
      send_request(make_req(olst_pkg::CMD_INSERT, 4, 32'shAAAA_AAAA));
      send_request(make_req(olst_pkg::CMD_DELETE, 7, 0));
      send_request(make_req(olst_pkg::CMD_DELETE, 1, 0));
      send_request(make_req(olst_pkg::CMD_DELETE, 2, 0));
      send_request(make_req(olst_pkg::CMD_SEARCH, 0, 32'shAAAA_AAAA));

      // Random: no idling, sender idle, receiver stall, both
      run_random_phase(0, 0);
      run_random_phase(83, 0);
      run_random_phase(0, 83);
      run_random_phase(20, 20);
      req_valid <= 1'b0;

      // Drain outstanding responses, then let the core settle
      while (sb.awaited_rsp_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- positional_ordered_list_core.f -----
src/olst_pkg.sv
src/olst_ram.sv
src/positional_ordered_list_core.sv
src/olst_check.sv
dv/tb_positional_ordered_list_core.sv
